[design/aesp_pkg.sv]
// Package for the allocation event stream parser: types and constants.
`timescale 1ns / 1ps
package aesp_pkg;

  localparam int unsigned QueueDepth = 4;

  // Record types carried in header bits 1..0, and event kinds in bits 3..2.
  localparam logic [1:0] TYPE_BAD   = 2'd0;
  localparam logic [1:0] TYPE_EVENT = 2'd1;
  localparam logic [1:0] TYPE_STAMP = 2'd2;
  localparam logic [1:0] TYPE_NAME  = 2'd3;
  localparam logic [1:0] EV_ALLOC   = 2'd0;
  localparam logic [1:0] EV_RESIZE  = 2'd1;
  localparam logic [1:0] EV_FREE    = 2'd2;
  localparam logic [1:0] EV_BAD     = 2'd3;

  typedef enum logic [2:0] {
    KIND_ALLOC    = 3'd0,
    KIND_FREE     = 3'd1,
    KIND_STARTED  = 3'd2,
    KIND_FINISHED = 3'd3,
    KIND_TRACE    = 3'd4,
    KIND_NBEGIN   = 3'd5,
    KIND_NBYTE    = 3'd6,
    KIND_INVALID  = 3'd7
  } kind_t;

  // One decoded command handed from front to back.
  typedef struct packed {
    logic         two;     // a second record follows in the same command
    kind_t        kind0;
    logic [63:0]  time0;
    logic [63:0]  addr0;
    logic [63:0]  size0;
    logic [15:0]  tlen;
    logic [31:0]  sid;
    logic [7:0]   nlen;
    logic [7:0]   nbyte;
    logic [63:0]  addr1;
    logic [63:0]  size1;
  } cmd_t;

  typedef struct packed {
    kind_t        kind;
    logic [63:0]  time_value;
    logic [63:0]  block_address;
    logic [63:0]  block_size;
    logic [15:0]  trace_length;
    logic [31:0]  scope_id;
    logic [7:0]   name_length;
    logic [7:0]   name_byte;
    logic         last_of_run;
  } rec_t;

endpackage

[design/aesp_front.sv]
// Front end: byte-serial parser that turns stream bytes into commands.
`timescale 1ns / 1ps
module aesp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      data_byte,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output aesp_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    PH_HDR    = 10'b0000000001,
    PH_STAMP  = 10'b0000000010,
    PH_W0     = 10'b0000000100,
    PH_W1     = 10'b0000001000,
    PH_W2     = 10'b0000010000,
    PH_CNT    = 10'b0000100000,
    PH_TRACE  = 10'b0001000000,
    PH_NSTAMP = 10'b0010000000,
    PH_NLEN   = 10'b0100000000,
    PH_NBYTE  = 10'b1000000000
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [7:0]   hdr_r, hdr_nxt;
  logic [3:0]   idx_r, idx_nxt;
  logic [63:0]  stamp_r, stamp_nxt, start_r, start_nxt;
  logic [63:0]  w_r [3];
  logic [63:0]  w_nxt [3];
  logic [15:0]  trem_r, trem_nxt;
  logic [31:0]  scope_r, scope_nxt;
  logic [7:0]   nrem_r, nrem_nxt;
  logic         halt_r, halt_nxt;

  logic         fire;
  logic [1:0]   kind;
  logic [3:0]   wbytes;
  logic [5:0]   sh;
  logic [63:0]  bext;
  logic [15:0]  cnt_full;
  logic [63:0]  rel;
  logic [3:0]   idx_inc;
  logic [1:0]   nwords;

  assign byte_ready = cmd_ready;
  assign fire   = byte_valid && byte_ready && !halt_r;
  assign kind   = hdr_r[3:2];
  assign wbytes = hdr_r[7] ? 4'd8 : 4'd4;
  assign sh     = {idx_r[2:0], 3'b000};
  assign bext   = {56'd0, data_byte} << sh;
  assign cnt_full = {data_byte, trem_r[7:0]};
  assign rel    = stamp_r - start_r;
  assign idx_inc = idx_r + 4'd1;
  assign nwords = (kind == aesp_pkg::EV_ALLOC) ? 2'd2 :
                  (kind == aesp_pkg::EV_RESIZE) ? 2'd3 : 2'd1;

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    idx_nxt   = idx_r;
    stamp_nxt = stamp_r;
    start_nxt = start_r;
    w_nxt     = w_r;
    trem_nxt  = trem_r;
    scope_nxt = scope_r;
    nrem_nxt  = nrem_r;
    halt_nxt  = halt_r;
    cmd_valid = 1'b0;
    cmd       = '0;
    if (fire) begin
      unique case (phase_r)
        PH_STAMP: begin
          stamp_nxt = stamp_r | bext;
          idx_nxt = idx_inc;
          if (idx_inc == 4'd8) begin
            idx_nxt = '0;
            if (hdr_r[1:0] == aesp_pkg::TYPE_STAMP) begin
              cmd_valid = 1'b1;
              cmd.time0 = stamp_r | bext;
              if (!hdr_r[2]) begin
                start_nxt = stamp_r | bext;
                cmd.kind0 = aesp_pkg::KIND_STARTED;
              end else begin
                cmd.kind0 = aesp_pkg::KIND_FINISHED;
              end
              phase_nxt = PH_HDR;
            end else begin
              phase_nxt = PH_W0;
            end
          end
        end
        PH_W0, PH_W1, PH_W2: begin
          logic [1:0] k;
          k = (phase_r == PH_W0) ? 2'd0 : (phase_r == PH_W1) ? 2'd1 : 2'd2;
          w_nxt[k] = w_r[k] | bext;
          idx_nxt = idx_inc;
          if (idx_inc >= wbytes) begin
            idx_nxt = '0;
            if (k + 2'd1 < nwords) begin
              phase_nxt = (k == 2'd0) ? PH_W1 : PH_W2;
            end else begin
              phase_nxt = PH_CNT;
              trem_nxt = '0;
            end
          end
        end
        PH_CNT: begin
          if (idx_r == 4'd0) begin
            trem_nxt = {8'd0, data_byte};
            idx_nxt = 4'd1;
          end else begin
            trem_nxt = cnt_full;
            idx_nxt = '0;
            cmd.time0 = rel;
            cmd.tlen = cnt_full;
            if (kind == aesp_pkg::EV_ALLOC) begin
              cmd_valid = 1'b1;
              cmd.kind0 = aesp_pkg::KIND_ALLOC;
              cmd.addr0 = w_r[0];
              cmd.size0 = w_r[1];
            end else if (kind == aesp_pkg::EV_RESIZE) begin
              cmd.addr1 = w_r[1];
              cmd.size1 = w_r[2];
              if (w_r[0] != '0) begin
                cmd_valid = 1'b1;
                cmd.kind0 = aesp_pkg::KIND_FREE;
                cmd.addr0 = w_r[0];
                cmd.two = (w_r[2] != '0);
              end else if (w_r[2] != '0) begin
                cmd_valid = 1'b1;
                cmd.kind0 = aesp_pkg::KIND_ALLOC;
                cmd.addr0 = w_r[1];
                cmd.size0 = w_r[2];
              end
            end else begin
              cmd_valid = 1'b1;
              cmd.kind0 = aesp_pkg::KIND_FREE;
              cmd.addr0 = w_r[0];
            end
            scope_nxt = '0;
            phase_nxt = (cnt_full != '0) ? PH_TRACE : PH_HDR;
          end
        end
        PH_TRACE: begin
          scope_nxt = scope_r | (32'({24'd0, data_byte}) << sh[4:0]);
          idx_nxt = idx_inc;
          if (idx_inc >= 4'd4) begin
            idx_nxt = '0;
            cmd_valid = 1'b1;
            cmd.kind0 = aesp_pkg::KIND_TRACE;
            cmd.sid = scope_r | (32'({24'd0, data_byte}) << sh[4:0]);
            scope_nxt = '0;
            trem_nxt = trem_r - 16'd1;
            if (trem_r == 16'd1) phase_nxt = PH_HDR;
          end
        end
        PH_NSTAMP: begin
          idx_nxt = idx_inc;
          if (idx_inc >= 4'd8) begin
            idx_nxt = '0;
            phase_nxt = PH_NLEN;
          end
        end
        PH_NLEN: begin
          nrem_nxt = data_byte;
          cmd_valid = 1'b1;
          cmd.kind0 = aesp_pkg::KIND_NBEGIN;
          cmd.nlen = data_byte;
          phase_nxt = (data_byte != '0) ? PH_NBYTE : PH_HDR;
        end
        PH_NBYTE: begin
          cmd_valid = 1'b1;
          cmd.kind0 = aesp_pkg::KIND_NBYTE;
          cmd.nbyte = data_byte;
          nrem_nxt = nrem_r - 8'd1;
          if (nrem_r == 8'd1) phase_nxt = PH_HDR;
        end
        default: begin
          hdr_nxt = data_byte;
          idx_nxt = '0;
          stamp_nxt = '0;
          w_nxt[0] = '0;
          w_nxt[1] = '0;
          w_nxt[2] = '0;
          if (data_byte[1:0] == aesp_pkg::TYPE_BAD ||
              (data_byte[1:0] == aesp_pkg::TYPE_EVENT &&
               data_byte[3:2] == aesp_pkg::EV_BAD)) begin
            cmd_valid = 1'b1;
            cmd.kind0 = aesp_pkg::KIND_INVALID;
            halt_nxt = 1'b1;
            phase_nxt = PH_HDR;
          end else if (data_byte[1:0] == aesp_pkg::TYPE_NAME) begin
            phase_nxt = PH_NSTAMP;
          end else begin
            phase_nxt = PH_STAMP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      hdr_r   <= '0;
      idx_r   <= '0;
      stamp_r <= '0;
      start_r <= '0;
      w_r[0]  <= '0;
      w_r[1]  <= '0;
      w_r[2]  <= '0;
      trem_r  <= '0;
      scope_r <= '0;
      nrem_r  <= '0;
      halt_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      idx_r   <= idx_nxt;
      stamp_r <= stamp_nxt;
      start_r <= start_nxt;
      w_r     <= w_nxt;
      trem_r  <= trem_nxt;
      scope_r <= scope_nxt;
      nrem_r  <= nrem_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

[design/aesp_queue.sv]
// Small command FIFO between the parser front and the record back end.
`timescale 1ns / 1ps
module aesp_queue #(
  parameter int unsigned Depth = aesp_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  aesp_pkg::cmd_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output aesp_pkg::cmd_t  rd_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  aesp_pkg::cmd_t   mem_r [Depth];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             wr_fire, rd_fire;

  assign wr_ready = (cnt_r != (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      if (rd_fire) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    end
  end

endmodule

[design/aesp_back.sv]
// Back end: expands commands into one or two result records with an output register.
`timescale 1ns / 1ps
module aesp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  aesp_pkg::cmd_t  cmd,
  output logic            rec_valid,
  input  logic            rec_ready,
  output aesp_pkg::rec_t  rec
);

  logic            vld_r;
  aesp_pkg::rec_t  rec_r;
  logic            second_r;   // current command still owes its second record
  logic            load;
  logic            take;

  assign rec_valid = vld_r;
  assign rec = rec_r;
  assign load = !vld_r || rec_ready;
  // A command leaves the queue once its final record is loaded.
  assign take = load && cmd_valid && (!cmd.two || second_r);
  assign cmd_ready = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      vld_r <= cmd_valid;
      if (cmd_valid) second_r <= cmd.two && !second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load && cmd_valid) begin
      rec_r.time_value   <= cmd.time0;
      rec_r.trace_length <= cmd.tlen;
      rec_r.scope_id     <= cmd.sid;
      rec_r.name_length  <= cmd.nlen;
      rec_r.name_byte    <= cmd.nbyte;
      if (second_r) begin
        rec_r.kind          <= aesp_pkg::KIND_ALLOC;
        rec_r.block_address <= cmd.addr1;
        rec_r.block_size    <= cmd.size1;
        rec_r.last_of_run   <= 1'b1;
      end else begin
        rec_r.kind          <= cmd.kind0;
        rec_r.block_address <= cmd.addr0;
        rec_r.block_size    <= cmd.size0;
        rec_r.last_of_run   <= !cmd.two;
      end
    end
  end

endmodule

[design/alloc_event_stream_parser.sv]
// Top level of the allocation event stream parser.
`timescale 1ns / 1ps
// Usage: stream bytes of a little-endian memory-event stream enter on the
// in_ channel, one byte per transfer. Records leave on the out_ channel,
// each with out_tlast set on the final record caused by one input byte.
// The front parser takes one byte per cycle while the FIFO has room, and
// turns record-completing bytes into commands; a short FIFO holds them;
// the back end expands each command into one record, or two for a resize
// that frees and allocates. Throughput: one byte per cycle while the FIFO
// has room; a two-record resize holds the back end for both records, and
// the FIFO absorbs that. A command is written into the FIFO when its
// completing byte transfers, and the output register then loads it from
// the FIFO and presents the record.
// Reset (synchronous, rst_n low) returns the parser to waiting for a header,
// clears the start stamp and the halt flag, and empties the FIFO.
// When the receiver stalls, the output register holds its record, the FIFO
// fills, and in_tready drops once the FIFO is full; no byte is lost.
// An invalid header gives one invalid record; later bytes are then accepted
// and dropped until reset.
module alloc_event_stream_parser #(
  parameter int unsigned QueueDepth = aesp_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,     // [7:0] data_byte
  output logic          out_tvalid,
  input  logic          out_tready,
  // [2:0] record_kind, [66:3] time_value, [130:67] block_address,
  // [194:131] block_size, [210:195] trace_length, [242:211] scope_id,
  // [250:243] name_length, [258:251] name_byte, [263:259] zero fill
  output logic [263:0]  out_tdata,
  output logic          out_tlast
);

  aesp_pkg::cmd_t  f_cmd, q_cmd;
  logic            f_valid, f_ready, q_valid, q_ready;
  aesp_pkg::rec_t  rec;

  aesp_front u_front (
    .clk, .rst_n,
    .byte_valid(in_tvalid), .byte_ready(in_tready), .data_byte(in_tdata),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  aesp_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  aesp_back u_back (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .rec_valid(out_tvalid), .rec_ready(out_tready), .rec(rec)
  );

  assign out_tdata = {5'd0, rec.name_byte, rec.name_length, rec.scope_id,
                      rec.trace_length, rec.block_size, rec.block_address,
                      rec.time_value, rec.kind};
  assign out_tlast = rec.last_of_run;

endmodule

[dv/alloc_event_stream_parser_test.sv]
// Self-checking testbench for the allocation event stream parser.
`timescale 1ns / 1ps
module alloc_event_stream_parser_test;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 16;

  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_STAMP  = 4'd1,
    PH_W0     = 4'd2,
    PH_W1     = 4'd3,
    PH_W2     = 4'd4,
    PH_CNT    = 4'd5,
    PH_TRACE  = 4'd6,
    PH_NSTAMP = 4'd7,
    PH_NLEN   = 4'd8,
    PH_NBYTE  = 4'd9
  } phase_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;     // [7:0] data_byte
  logic out_tvalid;
  logic out_tready;
  // [2:0] record_kind, [66:3] time_value, [130:67] block_address,
  // [194:131] block_size, [210:195] trace_length, [242:211] scope_id,
  // [250:243] name_length, [258:251] name_byte, [263:259] zero fill
  logic [263:0] out_tdata;
  logic out_tlast;

  alloc_event_stream_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // Bytes waiting to be sent, and the records the parser should produce.
  logic [7:0] pending_bytes[$];
  aesp_pkg::rec_t expected_records[$];
  int mismatch_count = 0;
  bit stimulus_done = 0;
  bit hold_sender = 0;
  bit quiet_stretch = 0;

  // Shadow copy of the parser's state.
  phase_t sh_phase;
  logic [7:0] sh_header;
  logic [3:0] sh_index;
  logic [63:0] sh_stamp;
  logic [63:0] sh_words[3];
  logic [63:0] sh_start;
  logic [15:0] sh_trace_left;
  logic [31:0] sh_scope;
  logic [7:0] sh_name_left;
  bit sh_halted;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic aesp_pkg::rec_t blank_record(aesp_pkg::kind_t k);
    aesp_pkg::rec_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // Advance the shadow parser by one byte and queue the records it causes.
  task automatic predict_byte(input logic [7:0] b);
    aesp_pkg::rec_t recs[$];
    aesp_pkg::rec_t r;
    logic [1:0] ev;
    int wbytes;
    int nwords;
    int k;
    logic [63:0] rel;
    ev = sh_header[3:2];
    wbytes = sh_header[7] ? 8 : 4;
    nwords = (ev == aesp_pkg::EV_ALLOC) ? 2 : (ev == aesp_pkg::EV_RESIZE) ? 3 : 1;
    if (sh_halted) return;
    case (sh_phase)
      PH_STAMP: begin
        sh_stamp[sh_index[2:0]*8 +: 8] = b;
        sh_index++;
        if (sh_index == 8) begin
          sh_index = 0;
          if (sh_header[1:0] == aesp_pkg::TYPE_STAMP) begin
            r = blank_record(sh_header[2] ? aesp_pkg::KIND_FINISHED
                                          : aesp_pkg::KIND_STARTED);
            r.time_value = sh_stamp;
            if (!sh_header[2]) sh_start = sh_stamp;
            recs.push_back(r);
            sh_phase = PH_HDR;
          end else begin
            sh_phase = PH_W0;
          end
        end
      end
      PH_W0, PH_W1, PH_W2: begin
        k = sh_phase - PH_W0;
        sh_words[k][sh_index[2:0]*8 +: 8] = b;
        sh_index++;
        if (sh_index >= wbytes) begin
          sh_index = 0;
          if (k + 1 < nwords) begin
            sh_phase = phase_t'(sh_phase + 1);
          end else begin
            sh_phase = PH_CNT;
            sh_trace_left = '0;
          end
        end
      end
      PH_CNT: begin
        if (sh_index == 0) begin
          sh_trace_left = {8'h00, b};
          sh_index = 1;
        end else begin
          rel = sh_stamp - sh_start;
          sh_trace_left[15:8] = b;
          sh_index = 0;
          if (ev == aesp_pkg::EV_ALLOC ||
              (ev == aesp_pkg::EV_RESIZE && sh_words[2] != 0)) begin
            r = blank_record(aesp_pkg::KIND_ALLOC);
            r.time_value = rel;
            r.block_address = (ev == aesp_pkg::EV_ALLOC) ? sh_words[0] : sh_words[1];
            r.block_size = (ev == aesp_pkg::EV_ALLOC) ? sh_words[1] : sh_words[2];
            r.trace_length = sh_trace_left;
            if (ev == aesp_pkg::EV_RESIZE && sh_words[0] != 0) begin
              aesp_pkg::rec_t f;
              f = blank_record(aesp_pkg::KIND_FREE);
              f.time_value = rel;
              f.block_address = sh_words[0];
              f.trace_length = sh_trace_left;
              recs.push_back(f);
            end
            recs.push_back(r);
          end else if (ev != aesp_pkg::EV_RESIZE || sh_words[0] != 0) begin
            r = blank_record(aesp_pkg::KIND_FREE);
            r.time_value = rel;
            r.block_address = sh_words[0];
            r.trace_length = sh_trace_left;
            recs.push_back(r);
          end
          sh_scope = '0;
          sh_phase = (sh_trace_left != 0) ? PH_TRACE : PH_HDR;
        end
      end
      PH_TRACE: begin
        sh_scope[sh_index[1:0]*8 +: 8] = b;
        sh_index++;
        if (sh_index >= 4) begin
          sh_index = 0;
          r = blank_record(aesp_pkg::KIND_TRACE);
          r.scope_id = sh_scope;
          recs.push_back(r);
          sh_scope = '0;
          sh_trace_left--;
          if (sh_trace_left == 0) sh_phase = PH_HDR;
        end
      end
      PH_NSTAMP: begin
        sh_index++;
        if (sh_index >= 8) begin
          sh_index = 0;
          sh_phase = PH_NLEN;
        end
      end
      PH_NLEN: begin
        sh_name_left = b;
        r = blank_record(aesp_pkg::KIND_NBEGIN);
        r.name_length = b;
        recs.push_back(r);
        sh_phase = (b != 0) ? PH_NBYTE : PH_HDR;
      end
      PH_NBYTE: begin
        r = blank_record(aesp_pkg::KIND_NBYTE);
        r.name_byte = b;
        recs.push_back(r);
        sh_name_left--;
        if (sh_name_left == 0) sh_phase = PH_HDR;
      end
      default: begin
        sh_header = b;
        sh_index = 0;
        sh_stamp = '0;
        sh_words = '{default: '0};
        if (b[1:0] == aesp_pkg::TYPE_BAD ||
            (b[1:0] == aesp_pkg::TYPE_EVENT && b[3:2] == aesp_pkg::EV_BAD)) begin
          recs.push_back(blank_record(aesp_pkg::KIND_INVALID));
          sh_halted = 1;
          sh_phase = PH_HDR;
        end else if (b[1:0] == aesp_pkg::TYPE_NAME) begin
          sh_phase = PH_NSTAMP;
        end else begin
          sh_phase = PH_STAMP;
        end
      end
    endcase
    if (recs.size() > 0) recs[recs.size()-1].last_of_run = 1;
    foreach (recs[i]) expected_records.push_back(recs[i]);
  endtask

  task automatic push_value(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) pending_bytes.push_back(v[i*8 +: 8]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly random values, with all-zero and all-one extremes mixed in so every bit toggles.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic push_stamp(input bit finish, input logic [63:0] stamp);
    pending_bytes.push_back({5'b0, finish, aesp_pkg::TYPE_STAMP});
    push_value(stamp, 8);
  endtask

  task automatic push_event(input logic [1:0] ev, input bit wide,
                            input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input int ntrace);
    int wb;
    int nwords;
    logic [7:0] hdr;
    wb = wide ? 8 : 4;
    nwords = (ev == aesp_pkg::EV_ALLOC) ? 2 : (ev == aesp_pkg::EV_RESIZE) ? 3 : 1;
    // Bits 6..4 of the header carry no meaning and are randomized.
    hdr = {wide, 3'($urandom_range(0, 7)), ev, aesp_pkg::TYPE_EVENT};
    pending_bytes.push_back(hdr);
    push_value(rand64(), 8);
    push_value(w0, wb);
    if (nwords > 1) push_value(w1, wb);
    if (nwords > 2) push_value(w2, wb);
    push_value(64'(ntrace), 2);
    for (int i = 0; i < ntrace; i++) push_value(64'($urandom()), 4);
  endtask

  task automatic push_name(input int len);
    pending_bytes.push_back({6'($urandom_range(0, 63)), aesp_pkg::TYPE_NAME});
    push_value(rand64(), 8);
    pending_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random well-formed record; trace counts stay small so runs stay short.
  task automatic push_random_record();
    case ($urandom_range(0, 9))
      0, 1: push_stamp(1'($urandom_range(0, 1)), rand64());
      2, 3, 4, 5, 6, 7: push_event(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                                   pick_word(), pick_word(), pick_word(),
                                   int'($urandom_range(0, 3)));
      default: push_name(int'($urandom_range(0, 6)));
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Driver: presents queued bytes, with random gaps outside the quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_byte(in_tdata);
      if (pending_bytes.size() > 0 && !hold_sender &&
          (quiet_stretch || $urandom_range(0, 99) >= 6)) begin
        in_tvalid <= 1;
        in_tdata <= pending_bytes.pop_front();
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // Monitor: compares each record transfer with the oldest expectation.
  always @(posedge clk) begin
    aesp_pkg::rec_t got;
    aesp_pkg::rec_t want;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind          = aesp_pkg::kind_t'(out_tdata[2:0]);
        got.time_value    = out_tdata[66:3];
        got.block_address = out_tdata[130:67];
        got.block_size    = out_tdata[194:131];
        got.trace_length  = out_tdata[210:195];
        got.scope_id      = out_tdata[242:211];
        got.name_length   = out_tdata[250:243];
        got.name_byte     = out_tdata[258:251];
        got.last_of_run   = out_tlast;
        if (out_tdata[263:259] != 0)
          report_mismatch("fill", 64'(out_tdata[263:259]), 64'd0);
        if (expected_records.size() == 0) begin
          report_mismatch("unexpected record", 64'(got.kind), 64'd0);
        end else begin
          want = expected_records.pop_front();
          if (got.kind != want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
          if (got.time_value != want.time_value)
            report_mismatch("time", got.time_value, want.time_value);
          if (got.block_address != want.block_address)
            report_mismatch("address", got.block_address, want.block_address);
          if (got.block_size != want.block_size)
            report_mismatch("size", got.block_size, want.block_size);
          if (got.trace_length != want.trace_length)
            report_mismatch("trace length", 64'(got.trace_length),
                            64'(want.trace_length));
          if (got.scope_id != want.scope_id)
            report_mismatch("scope id", 64'(got.scope_id), 64'(want.scope_id));
          if (got.name_length != want.name_length)
            report_mismatch("name length", 64'(got.name_length),
                            64'(want.name_length));
          if (got.name_byte != want.name_byte)
            report_mismatch("name byte", 64'(got.name_byte), 64'(want.name_byte));
          if (got.last_of_run != want.last_of_run)
            report_mismatch("last", 64'(got.last_of_run), 64'(want.last_of_run));
        end
      end
      out_tready <= quiet_stretch || $urandom_range(0, 99) >= 6;
    end
  end

  // Watchdog: counts cycles with no transfer on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_sent();
    while (pending_bytes.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    sh_phase = PH_HDR;
    sh_header = '0;
    sh_index = '0;
    sh_stamp = '0;
    sh_words = '{default: '0};
    sh_start = '0;
    sh_trace_left = '0;
    sh_scope = '0;
    sh_name_left = '0;
    sh_halted = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: start and finish stamps, every event kind, resizes in both word sizes
    // with a zero old or new block, a zero trace count, names.
    push_stamp(0, '1);
    push_event(aesp_pkg::EV_ALLOC, 1, '1, '1, 0, 1);
    push_event(aesp_pkg::EV_FREE, 0, 64'hffff_ffff, 0, 0, 0);
    push_event(aesp_pkg::EV_RESIZE, 1, 64'h10, 64'h20, 64'h30, 0);
    push_event(aesp_pkg::EV_RESIZE, 0, 0, 64'h20, 64'h30, 0);
    push_event(aesp_pkg::EV_RESIZE, 0, 64'h10, 64'h20, 0, 0);
    push_event(aesp_pkg::EV_RESIZE, 1, 0, 0, 0, 1);
    push_stamp(1, 0);
    push_name(0);
    push_name(2);

    // The sender waits once with the parser fully drained.
    wait_sent();
    hold_sender = 1;
    while (expected_records.size() > 0) @(posedge clk);
    hold_sender = 0;

    // Random well-formed records, with a quiet stretch in the middle.
    while (pending_bytes.size() < 1450) push_random_record();
    while (pending_bytes.size() > 950) @(posedge clk);
    quiet_stretch = 1;
    while (pending_bytes.size() > 550) @(posedge clk);
    quiet_stretch = 0;
    wait_sent();

    // A bad header halts the parser; trailing noise must be ignored.
    pending_bytes.push_back({6'($urandom_range(0, 63)), aesp_pkg::TYPE_BAD});
    for (int i = 0; i < 30; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
    wait_sent();
    stimulus_done = 1;

    while (expected_records.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
